// ===== rtl/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants for the ranged LCG random number block.
// ----------------------------------------------------------------------------
package lrr_pkg;

    // LCG recurrence and draw constants
    localparam logic [31:0] LCG_MULT  = 32'h015A4E35;
    localparam logic [31:0] LCG_INC   = 32'd1;
    localparam logic [30:0] LOW_LIMIT = 31'h7FFF;
    localparam int          LOW_SHIFT = 16;

    // Serial multiplier: one 4-bit digit of the multiplier constant per cycle
    localparam int MUL_DIGIT_W = 4;
    localparam int MUL_STEPS   = 32 / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    // Serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operation codes
    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_DRAW    = 3'd1;
    localparam logic [2:0] OP_DRAW_LO = 3'd2;
    localparam logic [2:0] OP_ADVANCE = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    // Status returned by each serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/lrr_mul.sv =====
// ----------------------------------------------------------------------------
// lrr_mul
// Digit-serial multiplier by the LCG constant, product taken mod 2^32.
// ----------------------------------------------------------------------------
module lrr_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        mcand,
    output lrr_pkg::unit_stat_t stat,
    output logic [31:0]        product
);

    localparam logic [lrr_pkg::MUL_CNT_W-1:0] LAST_STEP =
        lrr_pkg::MUL_CNT_W'(lrr_pkg::MUL_STEPS - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [lrr_pkg::MUL_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]                    mcand_reg, mcand_next;
    logic [31:0]                    acc_reg, acc_next;
    logic [lrr_pkg::MUL_DIGIT_W-1:0] digit;
    logic [31:0]                    partial;

    assign digit   = lrr_pkg::LCG_MULT[cnt_reg * lrr_pkg::MUL_DIGIT_W +: lrr_pkg::MUL_DIGIT_W];
    assign partial = mcand_reg * 32'(digit);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = mcand;
            acc_next   = '0;
        end
        else if (busy_reg)
        begin
            // add one shifted digit product, then move to the next digit
            acc_next   = acc_reg + partial;
            mcand_next = mcand_reg << lrr_pkg::MUL_DIGIT_W;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

// ===== rtl/lrr_div.sv =====
// ----------------------------------------------------------------------------
// lrr_div
// Bit-serial restoring divider returning the remainder of a 32-bit
// dividend by a positive 31-bit divisor.
// ----------------------------------------------------------------------------
module lrr_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        dividend,
    input  logic [30:0]        divisor,
    output lrr_pkg::unit_stat_t stat,
    output logic [30:0]        remainder
);

    localparam logic [lrr_pkg::DIV_CNT_W-1:0] LAST_STEP =
        lrr_pkg::DIV_CNT_W'(lrr_pkg::DIV_STEPS - 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [lrr_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]                    dvd_reg, dvd_next;
    logic [30:0]                    dsr_reg, dsr_next;
    logic [30:0]                    rem_reg, rem_next;
    logic [31:0]                    trial;
    logic [32:0]                    diff;

    // bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // restore on a borrow
            if (diff[32])
                rem_next = trial[30:0];
            else
                rem_next = diff[30:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/lcg_ranged_random.sv =====
// ----------------------------------------------------------------------------
// lcg_ranged_random
// 32-bit linear congruential generator with load, read, advance and
// ranged draw requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and every request returns one result
// holding the drawn value and the seed after the request. Load, read and
// draws with a non-positive limit go straight to the result; an advance
// runs the digit-serial multiplier that walks the LCG constant 4 bits per
// cycle; a ranged draw runs the multiplier and then the bit-serial
// restoring divider that forms the remainder. The result sits in an output
// register until taken, and the next request is accepted once the result
// has moved there.
module lcg_ranged_random
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  logic signed [31:0] seed_value,
    input  logic signed [31:0] limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        draw_value,
    output logic signed [31:0] seed_now
);

    lrr_pkg::state_t     state_reg, state_next;
    lrr_pkg::unit_stat_t mul_stat, div_stat;

    logic        accept;
    logic        lim_ok;
    logic        mul_start, div_start, out_load;
    logic [31:0] mul_product;
    logic [30:0] div_rem;
    logic [31:0] mag;
    logic [31:0] dividend;

    logic [31:0] seed_reg, seed_next;
    logic [30:0] lim_reg, lim_next;
    logic        low_reg, low_next;
    logic        draw_flag_reg, draw_flag_next;
    logic [30:0] res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] draw_value_reg, draw_value_next;
    logic [31:0] seed_now_reg, seed_now_next;

    assign accept = in_valid && !in_stall;
    assign lim_ok = !limit[31] && (limit != '0);

    // magnitude of the new seed; the most negative value maps onto itself
    assign mag      = seed_reg[31] ? (~seed_reg + 32'd1) : seed_reg;
    assign dividend = low_reg ? (mag >> lrr_pkg::LOW_SHIFT) : mag;

    lrr_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (seed_reg),
        .stat    (mul_stat),
        .product (mul_product)
    );

    lrr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .divisor   (lim_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (((operation == lrr_pkg::OP_DRAW || operation == lrr_pkg::OP_DRAW_LO)
                         && lim_ok) || operation == lrr_pkg::OP_ADVANCE)
                        state_next = lrr_pkg::S_MUL;
                    else
                        state_next = lrr_pkg::S_DONE;
                end
            end
            lrr_pkg::S_MUL:
            begin
                if (mul_stat.done)
                    state_next = draw_flag_reg ? lrr_pkg::S_PREP : lrr_pkg::S_DONE;
            end
            lrr_pkg::S_PREP:
                state_next = lrr_pkg::S_DIV;
            lrr_pkg::S_DIV:
            begin
                if (div_stat.done)
                    state_next = lrr_pkg::S_DONE;
            end
            lrr_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = lrr_pkg::S_IDLE;
            end
            default:
                state_next = lrr_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            lrr_pkg::S_IDLE:
            begin
                in_stall  = 1'b0;
                mul_start = in_valid &&
                            (((operation == lrr_pkg::OP_DRAW ||
                               operation == lrr_pkg::OP_DRAW_LO) && lim_ok) ||
                             operation == lrr_pkg::OP_ADVANCE);
            end
            lrr_pkg::S_PREP:
                div_start = 1'b1;
            lrr_pkg::S_DONE:
                out_load = !out_valid_reg || !out_stall;
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        seed_next       = seed_reg;
        lim_next        = lim_reg;
        low_next        = low_reg;
        draw_flag_next  = draw_flag_reg;
        res_next        = res_reg;
        draw_value_next = draw_value_reg;
        seed_now_next   = seed_now_reg;

        if (accept)
        begin
            res_next       = '0;
            lim_next       = limit[30:0];
            low_next       = (operation == lrr_pkg::OP_DRAW_LO) ||
                             (limit[30:0] < lrr_pkg::LOW_LIMIT);
            draw_flag_next = (operation == lrr_pkg::OP_DRAW ||
                              operation == lrr_pkg::OP_DRAW_LO);
            if (operation == lrr_pkg::OP_LOAD)
                seed_next = seed_value;
        end

        // take the advanced seed
        if (state_reg == lrr_pkg::S_MUL && mul_stat.done)
            seed_next = mul_product + lrr_pkg::LCG_INC;

        if (state_reg == lrr_pkg::S_DIV && div_stat.done)
            res_next = div_rem;

        if (out_load)
        begin
            draw_value_next = res_reg;
            seed_now_next   = seed_reg;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrr_pkg::S_IDLE;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
            draw_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            draw_flag_reg <= draw_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg        <= lim_next;
        low_reg        <= low_next;
        res_reg        <= res_next;
        draw_value_reg <= draw_value_next;
        seed_now_reg   <= seed_now_next;
    end

    assign out_valid  = out_valid_reg;
    assign draw_value = draw_value_reg;
    assign seed_now   = seed_now_reg;

    // a finished remainder is always below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrr_pkg::S_DIV && div_stat.done) |-> (div_rem < lim_reg))
        else $error("remainder not below limit");

    // both serial units are quiet whenever a request may be accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrr_pkg::S_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
        else $error("serial unit busy while idle");

    // the seed holds while the divider works
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrr_pkg::S_DIV) |=> $stable(seed_reg))
        else $error("seed changed during divide");

    // a multiplier completion only arrives while waiting for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == lrr_pkg::S_MUL))
        else $error("multiplier finished outside its state");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lcg_ranged_random. Requests for every operation go
// in through the valid/stall port while both sides idle at random. A local
// copy of the seed predicts each result, and the result is checked against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes the block does not define; they behave as a read
    localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
    localparam int          TAIL_CYCLES = 60;

    typedef struct {
        logic [2:0]  op;
        logic [30:0] draw;
        logic [31:0] seed;
    } draw_result_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [2:0]         operation  = lrr_pkg::OP_READ;
    logic signed [31:0] seed_value = '0;
    logic signed [31:0] limit      = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [30:0]        draw_value;
    logic signed [31:0] seed_now;

    logic [31:0]        lcg_seed = '0;
    draw_result_t       expected_draws[$];
    int unsigned        mismatch_count = 0;
    bit                 tx_calm = 1'b0;
    bit                 rx_calm = 1'b0;
    int unsigned        stall_hold = 0;

    lcg_ranged_random u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .seed_value (seed_value),
        .limit      (limit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .draw_value (draw_value),
        .seed_now   (seed_now)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] next_seed(input logic [31:0] s);
        return s * lrr_pkg::LCG_MULT + lrr_pkg::LCG_INC;
    endfunction

    function automatic logic [30:0] lcg_draw(input logic [31:0] lim, input bit low_mode);
        logic [31:0] mag;
        // non-positive limit: no advance, zero result
        if (lim == '0 || lim[31])
            return '0;
        lcg_seed = next_seed(lcg_seed);
        mag = (lcg_seed[31] && lcg_seed != MOST_NEG) ? -lcg_seed : lcg_seed;
        if (low_mode || lim < 32'(lrr_pkg::LOW_LIMIT))
            mag = mag >> lrr_pkg::LOW_SHIFT;
        return 31'(mag % lim);
    endfunction

    function automatic void lcg_update(input logic [2:0] op, input logic [31:0] sv,
                                       input logic [31:0] lim);
        draw_result_t r;
        r.op   = op;
        r.draw = '0;
        case (op)
            lrr_pkg::OP_LOAD:    lcg_seed = sv;
            lrr_pkg::OP_DRAW:    r.draw = lcg_draw(lim, 1'b0);
            lrr_pkg::OP_DRAW_LO: r.draw = lcg_draw(lim, 1'b1);
            lrr_pkg::OP_ADVANCE: lcg_seed = next_seed(lcg_seed);
            default:             ;
        endcase
        r.seed = lcg_seed;
        expected_draws.push_back(r);
    endfunction

    // Leaves valid high after acceptance; a gap in the next call or the caller drops it
    task automatic send_request(input logic [2:0] op, input logic [31:0] sv,
                                input logic [31:0] lim);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        seed_value <= sv;
        limit      <= lim;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        lcg_update(op, sv, lim);
    endtask

    function automatic logic [31:0] random_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return MOST_NEG | $urandom;
            2:       return $urandom_range(1, 16);
            3, 4:    return $urandom_range(1, 32'h7FFE);
            5:       return 32'(lrr_pkg::LOW_LIMIT) + $urandom_range(0, 2) - 1;
            6:       return $urandom_range(32'h8000, MOST_POS);
            7:       return MOST_POS - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_request();
        int          roll;
        logic [2:0]  op;
        logic [31:0] sv;
        roll = $urandom_range(0, 19);
        if (roll < 7)
            op = lrr_pkg::OP_DRAW;
        else if (roll < 12)
            op = lrr_pkg::OP_DRAW_LO;
        else if (roll < 14)
            op = lrr_pkg::OP_LOAD;
        else if (roll < 16)
            op = lrr_pkg::OP_ADVANCE;
        else if (roll < 18)
            op = lrr_pkg::OP_READ;
        else
            op = 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        case ($urandom_range(0, 7))
            0:       sv = MOST_NEG;
            1:       sv = '1;
            2:       sv = '0;
            default: sv = $urandom;
        endcase
        send_request(op, sv, random_limit());
    endtask

    task automatic test_directed();
        logic [31:0] inv;
        logic [31:0] pre_seed;
        // seed whose successor is the most negative value
        inv = lrr_pkg::LCG_MULT;
        repeat (5) inv = inv * (32'd2 - lrr_pkg::LCG_MULT * inv);
        pre_seed = (MOST_NEG - lrr_pkg::LCG_INC) * inv;

        send_request(lrr_pkg::OP_READ, $urandom, $urandom);
        send_request(lrr_pkg::OP_ADVANCE, $urandom, $urandom);
        send_request(lrr_pkg::OP_DRAW, $urandom, '0);
        send_request(lrr_pkg::OP_DRAW, $urandom, MOST_NEG);
        send_request(lrr_pkg::OP_DRAW_LO, $urandom, '1);
        send_request(lrr_pkg::OP_DRAW_LO, $urandom, '0);
        send_request(lrr_pkg::OP_LOAD, MOST_POS, $urandom);
        send_request(lrr_pkg::OP_DRAW, $urandom, 32'd1);
        send_request(lrr_pkg::OP_DRAW, $urandom, 32'(lrr_pkg::LOW_LIMIT) - 1);
        send_request(lrr_pkg::OP_DRAW, $urandom, 32'(lrr_pkg::LOW_LIMIT));
        send_request(lrr_pkg::OP_DRAW, $urandom, MOST_POS);
        send_request(lrr_pkg::OP_DRAW_LO, $urandom, MOST_POS);
        send_request(lrr_pkg::OP_DRAW_LO, $urandom, 32'd1);
        send_request(lrr_pkg::OP_LOAD, MOST_NEG, $urandom);
        send_request(lrr_pkg::OP_ADVANCE, $urandom, $urandom);
        send_request(lrr_pkg::OP_LOAD, pre_seed, $urandom);
        send_request(lrr_pkg::OP_DRAW, $urandom, MOST_POS);
        send_request(lrr_pkg::OP_LOAD, pre_seed, $urandom);
        send_request(lrr_pkg::OP_DRAW_LO, $urandom, MOST_POS);
        send_request(lrr_pkg::OP_LOAD, pre_seed, $urandom);
        send_request(lrr_pkg::OP_DRAW, $urandom, 32'd1000);
        for (int op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++)
            send_request(3'(op), $urandom, $urandom);
        send_request(lrr_pkg::OP_LOAD, '1, $urandom);
        send_request(lrr_pkg::OP_READ, $urandom, $urandom);
    endtask

    task automatic test_random_mix();
        repeat (580) send_random_request();
    endtask

    task automatic test_back_to_back();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (300) send_random_request();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_drain_pauses();
        repeat (12)
        begin
            repeat ($urandom_range(5, 30)) send_random_request();
            // hold off until every result is back
            in_valid <= 1'b0;
            while (expected_draws.size() != 0) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= !rx_calm && ($urandom_range(0, 3) == 0);
            stall_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_draws.size() == 0)
            begin
                $error("unexpected result: draw_value %0d, seed_now %h", draw_value, seed_now);
                mismatch_count++;
            end
            else
            begin
                want = expected_draws.pop_front();
                if (draw_value !== want.draw)
                begin
                    $error("draw_value (op %0d): expected %0d, actual %0d",
                           want.op, want.draw, draw_value);
                    mismatch_count++;
                end
                if (seed_now !== want.seed)
                begin
                    $error("seed_now (op %0d): expected %h, actual %h",
                           want.op, want.seed, seed_now);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_mix();
        test_back_to_back();
        test_drain_pauses();
        test_random_mix();
        in_valid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_draws.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lrr_pkg.sv
rtl/lrr_mul.sv
rtl/lrr_div.sv
rtl/lcg_ranged_random.sv
dv/testbench.sv
